// ===== rtl/core/vfcp_pkg.sv =====
package vfcp_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_start;
        logic        keyframe;
        logic [31:0] seq_no;
        logic [63:0] stamp_ns;
        logic [31:0] frame_width;
        logic [31:0] frame_height;
        logic [31:0] header_len;
        logic [31:0] payload_len;
    } vfcp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header_byte;
        logic       last_of_chunk;
        logic       last_of_frame;
        logic [2:0] status;
        logic       end_of_item;
    } vfcp_out_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_OVER32 = 3'd2;
    localparam logic [2:0] ST_CHUNKS = 3'd3;
    localparam logic [2:0] ST_STRAY  = 3'd4;

    localparam int unsigned HDR_BYTES = 42;
    localparam int unsigned MAX_CHUNKS = 65535;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } vfcp_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } vfcp_div_rsp_t;

endpackage

// ===== rtl/core/vfcp_divider.sv =====
module vfcp_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vfcp_pkg::vfcp_div_req_t req,
    output vfcp_pkg::vfcp_div_rsp_t rsp
);
    import vfcp_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[31]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // done pulses only after a run
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider did not start");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 6'd0)
        else $error("divider count underflow");

endmodule

// ===== rtl/core/video_frame_chunk_packetizer.sv =====
// Video frame chunk packetizer. Bytes enter one at a time on s_; each accepted
// byte yields one result on m_, preceded by a 42-byte big-endian chunk header
// whenever it opens a chunk. A byte is accepted, then its result is loaded; a
// chunk-opening byte first sends its header bytes, one per cycle as m_ready
// allows. A frame_start byte first runs a bit-serial divider for the chunk
// count. Errors and stray bytes give a single status result. A result held
// back by m_ready stalls the block until it is taken.
module video_frame_chunk_packetizer #(
    parameter logic [31:0] DEFAULT_CHUNK_BYTES = 32'd1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vfcp_pkg::vfcp_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vfcp_pkg::vfcp_out_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vfcp_pkg::*;

    localparam logic [2:0] ADDR_MAX_CHUNK = 3'd0;
    localparam logic [2:0] ADDR_MSG_TYPE  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_HDR, S_DATA, S_ERR
    } state_t;

    state_t      state_reg;
    logic [31:0] max_chunk_reg;
    logic [7:0]  msg_type_reg;

    logic [7:0]  byte_reg;
    logic [31:0] seq_reg, width_reg, height_reg, hlen_reg, plen_reg;
    logic [63:0] ts_reg;
    logic        key_reg;
    logic [15:0] total_chunks_reg, chunk_num_reg;
    logic [31:0] offset_reg, left_reg, eff_reg, total_reg, len_reg;
    logic        open_reg;
    logic [5:0]  hidx_reg;
    logic [2:0]  err_reg;
    logic        mv_reg;
    vfcp_out_t   mo_reg;

    vfcp_div_req_t div_req;
    vfcp_div_rsp_t div_rsp;

    vfcp_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // config port
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            ADDR_MAX_CHUNK: prdata = max_chunk_reg;
            ADDR_MSG_TYPE:  prdata = {24'd0, msg_type_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chunk_reg <= '0;
            msg_type_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_MAX_CHUNK) max_chunk_reg <= pwdata;
            if (paddr == ADDR_MSG_TYPE)  msg_type_reg  <= pwdata[7:0];
        end
    end

    // frame planning from sampled metadata
    logic [32:0] sum_w;
    logic [31:0] eff_w, remain_w, len_w;
    logic [7:0]  flags_w, hbyte;
    logic [335:0] hdr_w;
    assign sum_w    = {1'b0, s_data.header_len} + {1'b0, s_data.payload_len};
    assign eff_w    = (max_chunk_reg != 32'd0) ? max_chunk_reg
                    : ((DEFAULT_CHUNK_BYTES != 32'd0) ? DEFAULT_CHUNK_BYTES : 32'd1);
    assign remain_w = total_reg - offset_reg;
    assign len_w    = (eff_reg < remain_w) ? eff_reg : remain_w;
    assign flags_w  = {5'd0, (chunk_num_reg + 16'd1) == total_chunks_reg,
                       chunk_num_reg == 16'd0, key_reg};
    assign hdr_w = {msg_type_reg, seq_reg, chunk_num_reg, total_chunks_reg, flags_w,
                    ts_reg, width_reg, height_reg, hlen_reg, plen_reg, offset_reg,
                    len_reg};
    // header byte select, first byte in the top bits
    assign hbyte = hdr_w[335 - 8*hidx_reg -: 8];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = mo_reg;

    logic s_fire, m_free, emit_w;
    assign s_fire = s_valid && s_ready;
    assign m_free = !mv_reg || m_ready;
    // a new result is loaded into the output register this cycle
    assign emit_w = m_free && (state_reg == S_ERR || state_reg == S_HDR
                               || state_reg == S_DATA);

    always_comb begin
        div_req.start    = s_fire && s_data.frame_start && sum_w != 33'd0 && !sum_w[32];
        div_req.dividend = sum_w[31:0] - 32'd1;
        div_req.divisor  = eff_w;
    end

    logic [31:0] quo1;
    assign quo1 = div_rsp.quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            open_reg  <= 1'b0;
            seq_reg <= '0; ts_reg <= '0; width_reg <= '0; height_reg <= '0;
            key_reg <= 1'b0; hlen_reg <= '0; plen_reg <= '0;
            total_chunks_reg <= '0; chunk_num_reg <= '0; offset_reg <= '0;
            left_reg <= '0; eff_reg <= '0; total_reg <= '0;
            hidx_reg <= '0; err_reg <= '0;
        end else begin
            if (mv_reg && m_ready && !emit_w) mv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        byte_reg <= s_data.data_byte;
                        if (s_data.frame_start) begin
                            open_reg   <= 1'b0;
                            key_reg    <= s_data.keyframe;
                            seq_reg    <= s_data.seq_no;
                            ts_reg     <= s_data.stamp_ns;
                            width_reg  <= s_data.frame_width;
                            height_reg <= s_data.frame_height;
                            hlen_reg   <= s_data.header_len;
                            plen_reg   <= s_data.payload_len;
                            total_reg  <= sum_w[31:0];
                            eff_reg    <= eff_w;
                            if (sum_w == 33'd0) begin
                                err_reg <= ST_EMPTY; state_reg <= S_ERR;
                            end else if (sum_w[32]) begin
                                err_reg <= ST_OVER32; state_reg <= S_ERR;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end else if (!open_reg) begin
                            err_reg <= ST_STRAY; state_reg <= S_ERR;
                        end else if (left_reg == 32'd0) begin
                            len_reg <= len_w; hidx_reg <= '0; state_reg <= S_HDR;
                        end else begin
                            state_reg <= S_DATA;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (quo1 >= MAX_CHUNKS) begin
                            err_reg <= ST_CHUNKS; state_reg <= S_ERR;
                        end else begin
                            total_chunks_reg <= quo1[15:0] + 16'd1;
                            chunk_num_reg <= '0; offset_reg <= '0; left_reg <= '0;
                            open_reg <= 1'b1;
                            len_reg  <= (eff_reg < total_reg) ? eff_reg : total_reg;
                            hidx_reg <= '0;
                            state_reg <= S_HDR;
                        end
                    end
                end
                S_ERR: begin
                    if (m_free) begin
                        mv_reg <= 1'b1;
                        mo_reg <= '{out_byte: 8'd0, is_header_byte: 1'b0,
                                    last_of_chunk: 1'b0, last_of_frame: 1'b0,
                                    status: err_reg, end_of_item: 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                S_HDR: begin
                    if (m_free) begin
                        mv_reg <= 1'b1;
                        mo_reg <= '{out_byte: hbyte, is_header_byte: 1'b1,
                                    last_of_chunk: 1'b0, last_of_frame: 1'b0,
                                    status: ST_OK, end_of_item: 1'b0};
                        if (hidx_reg == 6'(HDR_BYTES - 1)) begin
                            left_reg  <= len_reg;
                            state_reg <= S_DATA;
                        end
                        hidx_reg <= hidx_reg + 6'd1;
                    end
                end
                S_DATA: begin
                    if (m_free) begin
                        mv_reg <= 1'b1;
                        mo_reg <= '{out_byte: byte_reg, is_header_byte: 1'b0,
                                    last_of_chunk: left_reg == 32'd1,
                                    last_of_frame: (offset_reg + 32'd1) == total_reg,
                                    status: ST_OK, end_of_item: 1'b1};
                        left_reg   <= left_reg - 32'd1;
                        offset_reg <= offset_reg + 32'd1;
                        if (left_reg == 32'd1) chunk_num_reg <= chunk_num_reg + 16'd1;
                        if ((offset_reg + 32'd1) == total_reg) open_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("accepted while busy");
    a_hdr_then_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HDR && m_free && hidx_reg == 6'(HDR_BYTES - 1)) |=>
        state_reg == S_DATA)
        else $error("header not followed by data");
    a_err_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && mo_reg.status != ST_OK) |-> mo_reg.end_of_item && mo_reg.out_byte == 8'd0)
        else $error("bad error result");

endmodule

// ===== verif/video_frame_chunk_packetizer_chk.sv =====
module video_frame_chunk_packetizer_chk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  vfcp_pkg::vfcp_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  vfcp_pkg::vfcp_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  err_count,
    output int                  pending
);
    import vfcp_pkg::*;

    localparam logic [2:0]  ADDR_CHUNK = 3'd0;
    localparam logic [2:0]  ADDR_TYPE  = 3'd4;
    localparam logic [63:0] DEF_CHUNK  = 64'd1024;

    // register copies
    logic [31:0] cfg_chunk;
    logic [7:0]  cfg_type;

    // frame state
    logic [31:0] frm_seq, frm_w, frm_h, frm_hl, frm_pl;
    logic [63:0] frm_ts;
    logic        frm_key, frm_open;
    logic [15:0] n_chunks, chunk_idx;
    logic [31:0] frm_off, chunk_left, chunk_sz;

    vfcp_out_t stream_q[$];

    function automatic vfcp_out_t mk(logic [7:0] b, logic h, logic loc, logic lof,
                                     logic [2:0] st, logic eoi);
        vfcp_out_t r;
        r.out_byte = b;
        r.is_header_byte = h;
        r.last_of_chunk = loc;
        r.last_of_frame = lof;
        r.status = st;
        r.end_of_item = eoi;
        return r;
    endfunction

    // append one expected transfer at the tail
    function automatic void queue_add(vfcp_out_t r);
        stream_q.insert(stream_q.size(), r);
    endfunction

    // expected stream bytes for one accepted input byte
    task automatic packetize(input vfcp_in_t d);
        logic [63:0]  sum, eff, nch;
        logic [2:0]   code;
        logic [335:0] hdr;
        logic [31:0]  len;
        logic [7:0]   flg;
        logic         loc, lof;
        if (d.frame_start) begin
            frm_open = 1'b0;
            frm_key = d.keyframe;
            frm_seq = d.seq_no;
            frm_ts = d.stamp_ns;
            frm_w = d.frame_width;
            frm_h = d.frame_height;
            frm_hl = d.header_len;
            frm_pl = d.payload_len;
            eff = (cfg_chunk != 0) ? {32'd0, cfg_chunk} : DEF_CHUNK;
            sum = {32'd0, d.header_len} + {32'd0, d.payload_len};
            code = ST_OK;
            if (sum == 0) begin
                code = ST_EMPTY;
            end else if (sum > 64'hFFFF_FFFF) begin
                code = ST_OVER32;
            end else begin
                nch = (sum - 1) / eff + 1;
                if (nch > MAX_CHUNKS) code = ST_CHUNKS;
                else n_chunks = nch[15:0];
            end
            if (code != ST_OK) begin
                queue_add(mk(8'd0, 1'b0, 1'b0, 1'b0, code, 1'b1));
                return;
            end
            chunk_sz = eff[31:0];
            chunk_idx = '0;
            frm_off = '0;
            chunk_left = '0;
            frm_open = 1'b1;
        end else if (!frm_open) begin
            queue_add(mk(8'd0, 1'b0, 1'b0, 1'b0, ST_STRAY, 1'b1));
            return;
        end
        sum = {32'd0, frm_hl} + {32'd0, frm_pl};
        // chunk header ahead of the first byte of each chunk
        if (chunk_left == 0) begin
            len = ({32'd0, chunk_sz} < sum - frm_off) ? chunk_sz : 32'(sum - frm_off);
            flg = {5'd0, (chunk_idx + 16'd1 == n_chunks), (chunk_idx == 0), frm_key};
            hdr = {cfg_type, frm_seq, chunk_idx, n_chunks, flg, frm_ts, frm_w, frm_h,
                   frm_hl, frm_pl, frm_off, len};
            for (int i = 0; i < HDR_BYTES; i++)
                queue_add(mk(hdr[335 - 8 * i -: 8], 1'b1, 1'b0, 1'b0, ST_OK, 1'b0));
            chunk_left = len;
        end
        chunk_left = chunk_left - 1;
        frm_off = frm_off + 1;
        loc = (chunk_left == 0);
        lof = ({32'd0, frm_off} == sum);
        queue_add(mk(d.data_byte, 1'b0, loc, lof, ST_OK, 1'b1));
        if (loc) chunk_idx = chunk_idx + 16'd1;
        if (lof) frm_open = 1'b0;
    endtask

    assign pending = stream_q.size();

    // track register writes, predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        vfcp_out_t want;
        if (!aresetn) begin
            err_count = 0;
            cfg_chunk = '0; cfg_type = '0;
            frm_seq = '0; frm_w = '0; frm_h = '0; frm_hl = '0; frm_pl = '0;
            frm_ts = '0; frm_key = 1'b0; frm_open = 1'b0;
            n_chunks = '0; chunk_idx = '0; frm_off = '0; chunk_left = '0; chunk_sz = '0;
            stream_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_CHUNK) cfg_chunk = pwdata;
                else if (paddr == ADDR_TYPE) cfg_type = pwdata[7:0];
            end
            if (s_valid && s_ready) packetize(s_data);
            if (m_valid && m_ready) begin
                if (stream_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected transfer: got %p", m_data);
                end else begin
                    want = stream_q.pop_front();
                    if (m_data.out_byte !== want.out_byte
                        || m_data.is_header_byte !== want.is_header_byte
                        || m_data.last_of_chunk !== want.last_of_chunk
                        || m_data.last_of_frame !== want.last_of_frame
                        || m_data.status !== want.status
                        || m_data.end_of_item !== want.end_of_item) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected %p got %p", want, m_data);
                    end
                end
            end
        end
    end

endmodule

// ===== verif/video_frame_chunk_packetizer_tb.sv =====
module video_frame_chunk_packetizer_tb;
    import vfcp_pkg::*;

    localparam logic [2:0] ADDR_CHUNK = 3'd0;
    localparam logic [2:0] ADDR_TYPE  = 3'd4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    vfcp_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    vfcp_out_t   m_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          err_count, pending;
    int          send_idle = 0, recv_idle = 0;
    bit          hold_req = 0;
    int          sent = 0;

    always #10 aclk = ~aclk;

    video_frame_chunk_packetizer DUT (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    video_frame_chunk_packetizer_chk u_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .err_count, .pending
    );

    // receiver: random backpressure, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                repeat (400) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_byte(input vfcp_in_t d);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic vfcp_in_t rand_item(logic fs);
        vfcp_in_t d;
        d.data_byte = 8'($urandom);
        d.frame_start = fs;
        d.keyframe = 1'($urandom);
        d.seq_no = $urandom;
        d.stamp_ns = {$urandom, $urandom};
        d.frame_width = $urandom;
        d.frame_height = $urandom;
        d.header_len = $urandom;
        d.payload_len = $urandom;
        return d;
    endfunction

    // one frame start plus nbytes-1 following bytes
    task automatic send_frame(input logic [31:0] hl, input logic [31:0] pl, input int nbytes);
        vfcp_in_t d;
        d = rand_item(1'b1);
        d.header_len = hl;
        d.payload_len = pl;
        send_byte(d);
        for (int i = 1; i < nbytes; i++) send_byte(rand_item(1'b0));
    endtask

    task automatic random_phase(input int n_items);
        int sel, hl, pl;
        int stop;
        stop = sent + n_items;
        while (sent < stop) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                hl = $urandom_range(0, 4);
                pl = $urandom_range(0, 12);
                send_frame(hl, pl, (sel < 65) ? hl + pl : $urandom_range(1, 3));
            end else if (sel < 88) begin
                send_frame($urandom, $urandom, $urandom_range(1, 3));
            end else begin
                send_byte(rand_item(1'b0));
            end
        end
    endtask

    task automatic set_config();
        int pick;
        pick = $urandom_range(5);
        unique case (pick)
            0: reg_write(ADDR_CHUNK, 32'd0);
            1: reg_write(ADDR_CHUNK, 32'hFFFF_FFFF);
            2: reg_write(ADDR_CHUNK, $urandom);
            default: reg_write(ADDR_CHUNK, $urandom_range(1, 6));
        endcase
        reg_write(ADDR_TYPE, $urandom_range(255));
    endtask

    initial begin
        vfcp_in_t d;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: default chunk size, errors, stray, abandon
        send_frame(32'd2, 32'd3, 5);
        send_byte(rand_item(1'b0));
        send_frame(32'd0, 32'd0, 1);
        send_frame(32'hFFFF_FFFF, 32'd1, 1);
        drain();
        reg_write(ADDR_CHUNK, 32'd1);
        reg_write(ADDR_TYPE, 32'd255);
        send_frame(32'd1, 32'hFFFF, 1);
        send_frame(32'd0, 32'hFFFF, 2);
        d = '1;
        d.header_len = 32'd1;
        d.payload_len = 32'd1;
        send_byte(d);
        d = '0;
        send_byte(d);
        drain();
        reg_write(ADDR_CHUNK, 32'd3);
        reg_write(ADDR_TYPE, 32'd0);
        send_frame(32'd4, 32'd5, 9);
        send_byte(rand_item(1'b0));
        drain();
        reg_write(ADDR_CHUNK, 32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF, 32'd0, 2);
        send_frame(32'd0, 32'd1, 1);
        drain();

        // random phases with different idling
        send_idle = 17; recv_idle = 81;
        set_config();
        random_phase(100);
        drain();
        send_idle = 81; recv_idle = 17;
        set_config();
        random_phase(100);
        drain();
        send_idle = 0; recv_idle = 0;
        reg_write(ADDR_CHUNK, 32'd2);
        hold_req = 1;
        send_frame(32'd3, 32'd9, 12);
        drain();
        set_config();
        random_phase(100);
        drain();

        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
